[sv/egf_pkg.sv]
// Shared types and constants for the elevation grid fuser.
// Used by elevation_grid_fuser_top; no other dependencies.
package egf_pkg;

  // Sequencer states: clear, idle, index lookup, cell read, multiply-accumulate steps, write, result
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COL,
    ST_ROW,
    ST_READ,
    ST_CALC,
    ST_E0,
    ST_E1,
    ST_MAG,
    ST_S0,
    ST_S1,
    ST_S2,
    ST_SQ,
    ST_V0,
    ST_V1,
    ST_V2,
    ST_VAR,
    ST_WRITE,
    ST_DONE
  } egf_state_e;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CELL_SHIFT  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GLOBAL_MODE = 2'd3;

  localparam logic [4:0] CELL_SHIFT_RESET = 5'd14;

  // Q16.16 variance of a fresh cell (0.01), Q0.16 blend weights
  localparam logic [31:0] VAR_INIT            = 32'd655;
  localparam logic [15:0] ALPHA_Q16           = 16'd9830;
  localparam logic [15:0] ONE_MINUS_ALPHA_Q16 = 16'd55706;

  // Shared multiplier: signed 18 x 34, accumulated into a 68-bit register
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 34;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = 68;

  localparam logic [5:0] SH_NONE = 6'd0;
  localparam logic [5:0] SH_MID  = 6'd17;
  localparam logic [5:0] SH_HI   = 6'd32;

endpackage

[sv/elevation_grid_fuser_top.sv]
// Elevation grid fuser top level: point-to-cell mapping, cell read-modify-write,
// shared multiply-accumulate sequencer. Depends on egf_pkg and egf_ram.
//
// One point word in, one result word out. After reset the block sweeps the cell
// known bits clear, one cell a cycle, 2^(2*GRID_SIDE_LOG2) cells (65536 at the
// default), and accepts no point until done; config writes are taken throughout.
// An invalid point goes straight to the result; one off the grid stops after its
// column or row lookup; a first hit or a global-mode hit adds the registered cell
// read and the write; a blend-mode hit adds the steps in which the single 18x34
// multiplier is used eight times in sequence for the new height, the squared
// residual and the new variance. Any wait for the output register comes on top.
module elevation_grid_fuser_top #(
  parameter int unsigned GRID_SIDE_LOG2 = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [egf_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [31:0]                      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [31:0]               point_x_i,
  input  logic signed [31:0]               point_y_i,
  input  logic signed [31:0]               point_z_i,
  input  logic                             point_valid_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic                             first_hit_o,
  output logic [15:0]                      cell_index_o,
  output logic signed [31:0]               new_elevation_o,
  output logic [31:0]                      new_variance_o
);

  import egf_pkg::*;

  localparam int unsigned G      = GRID_SIDE_LOG2;
  localparam int unsigned CELL_W = 2 * G;
  localparam int unsigned CELLS  = 1 << CELL_W;
  localparam int unsigned PAD_W  = CELL_W + 16;

  // configuration
  logic signed [31:0] ox_q, oy_q;
  logic [4:0]         shift_q;
  logic               gmode_q;

  // sequencer and item state
  egf_state_e         state_q, state_d;
  logic [CELL_W-1:0]  clr_cnt_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [G-1:0]       col_q;
  logic [CELL_W-1:0]  cell_q;
  logic signed [31:0] old_q;
  logic [31:0]        ov_q;
  logic [32:0]        mag_q;
  logic [48:0]        sq_q;
  logic signed [ACC_W-1:0] acc_q;
  logic               res_hit_q, res_first_q;
  logic signed [31:0] res_elev_q;
  logic [31:0]        res_var_q;

  // output register
  logic               out_valid_q;
  logic               out_hit_q, out_first_q;
  logic [15:0]        out_cell_q;
  logic signed [31:0] out_elev_q;
  logic [31:0]        out_var_q;

  // index unit: offset and floor shift, shared by x and y
  logic signed [32:0] ix_diff, ix_res;
  logic               ix_in_range;

  always_comb begin
    if (state_q == ST_ROW) begin
      ix_diff = {py_q[31], py_q} - {oy_q[31], oy_q};
    end else begin
      ix_diff = {px_q[31], px_q} - {ox_q[31], ox_q};
    end
    ix_res      = ix_diff >>> shift_q;
    ix_in_range = (ix_res[32:G] == '0);
  end

  // cell stores
  logic              kn_we, kn_wdata, kn_re, kn_rdata;
  logic [CELL_W-1:0] kn_waddr;
  logic              dt_we;
  logic [63:0]       dt_rdata;

  egf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_known_ram (
    .clk_i   (clk_i),
    .we_i    (kn_we),
    .waddr_i (kn_waddr),
    .wdata_i (kn_wdata),
    .re_i    (kn_re),
    .raddr_i (cell_q),
    .rdata_o (kn_rdata)
  );

  egf_ram #(.WIDTH(64), .DEPTH(CELLS)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dt_we),
    .waddr_i (cell_q),
    .wdata_i ({res_elev_q, res_var_q}),
    .re_i    (kn_re),
    .raddr_i (cell_q),
    .rdata_o (dt_rdata)
  );

  // shared multiply-accumulate unit
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [5:0]                mul_sh;
  logic                      acc_en, acc_clr;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext, acc_d;

  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod) <<< mul_sh;
  assign acc_d    = (acc_clr ? '0 : acc_q) + prod_ext;

  // residual magnitude halves, for the square
  logic [16:0] mag_hi;
  logic [15:0] mag_lo;
  assign mag_hi = mag_q[32:16];
  assign mag_lo = mag_q[15:0];

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_cnt_q == CELL_W'(CELLS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) state_d = point_valid_i ? ST_COL : ST_DONE;
      end
      ST_COL:   state_d = ix_in_range ? ST_ROW : ST_DONE;
      ST_ROW:   state_d = ix_in_range ? ST_READ : ST_DONE;
      ST_READ:  state_d = ST_CALC;
      ST_CALC:  state_d = (!kn_rdata || gmode_q) ? ST_WRITE : ST_E0;
      ST_E0:    state_d = ST_E1;
      ST_E1:    state_d = ST_MAG;
      ST_MAG:   state_d = ST_S0;
      ST_S0:    state_d = ST_S1;
      ST_S1:    state_d = ST_S2;
      ST_S2:    state_d = ST_SQ;
      ST_SQ:    state_d = ST_V0;
      ST_V0:    state_d = ST_V1;
      ST_V1:    state_d = ST_V2;
      ST_V2:    state_d = ST_VAR;
      ST_VAR:   state_d = ST_WRITE;
      ST_WRITE: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    kn_we      = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
    kn_waddr   = (state_q == ST_CLEAR) ? clr_cnt_q : cell_q;
    kn_wdata   = (state_q == ST_WRITE);
    kn_re      = (state_q == ST_READ);
    dt_we      = (state_q == ST_WRITE);
    mul_a      = '0;
    mul_b      = '0;
    mul_sh     = SH_NONE;
    acc_en     = 1'b1;
    acc_clr    = 1'b0;
    unique case (state_q)
      ST_E0: begin
        mul_a   = {2'b00, ONE_MINUS_ALPHA_Q16};
        mul_b   = {{2{old_q[31]}}, old_q};
        acc_clr = 1'b1;
      end
      ST_E1: begin
        mul_a = {2'b00, ALPHA_Q16};
        mul_b = {{2{pz_q[31]}}, pz_q};
      end
      // mag^2 = lo^2 + hi*lo*2^17 + hi^2*2^32
      ST_S0: begin
        mul_a   = {2'b00, mag_lo};
        mul_b   = {18'd0, mag_lo};
        acc_clr = 1'b1;
      end
      ST_S1: begin
        mul_a  = {1'b0, mag_hi};
        mul_b  = {18'd0, mag_lo};
        mul_sh = SH_MID;
      end
      ST_S2: begin
        mul_a  = {1'b0, mag_hi};
        mul_b  = {17'd0, mag_hi};
        mul_sh = SH_HI;
      end
      ST_V0: begin
        mul_a   = {2'b00, ONE_MINUS_ALPHA_Q16};
        mul_b   = {2'b00, ov_q};
        acc_clr = 1'b1;
      end
      ST_V1: begin
        mul_a = {2'b00, ALPHA_Q16};
        mul_b = {2'b00, sq_q[31:0]};
      end
      ST_V2: begin
        mul_a  = {2'b00, ALPHA_Q16};
        mul_b  = {17'd0, sq_q[48:32]};
        mul_sh = SH_HI;
      end
      default: acc_en = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      ox_q        <= '0;
      oy_q        <= '0;
      shift_q     <= CELL_SHIFT_RESET;
      gmode_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + CELL_W'(1);
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_ORIGIN_X:    ox_q    <= cfg_wdata_i;
          CFG_ORIGIN_Y:    oy_q    <= cfg_wdata_i;
          CFG_CELL_SHIFT:  shift_q <= cfg_wdata_i[4:0];
          CFG_GLOBAL_MODE: gmode_q <= cfg_wdata_i[0];
          default:         ;
        endcase
      end
    end
  end

  // datapath
  logic signed [32:0] gsum;
  logic signed [31:0] blend_elev;
  logic signed [32:0] resid;
  logic [PAD_W-1:0]   cell_pad;

  // global mode uses the stored height straight from the RAM read
  assign gsum       = {dt_rdata[63], dt_rdata[63:32]} + {pz_q[31], pz_q};
  assign blend_elev = acc_q[47:16];
  assign resid      = {pz_q[31], pz_q} - {blend_elev[31], blend_elev};
  assign cell_pad   = {16'd0, cell_q};

  always_ff @(posedge clk_i) begin
    if (acc_en) begin
      acc_q <= acc_d;
    end
    unique case (state_q)
      ST_IDLE: begin
        px_q        <= point_x_i;
        py_q        <= point_y_i;
        pz_q        <= point_z_i;
        res_hit_q   <= 1'b0;
        res_first_q <= 1'b0;
        res_elev_q  <= '0;
        res_var_q   <= '0;
      end
      ST_COL: col_q  <= ix_res[G-1:0];
      ST_ROW: cell_q <= {ix_res[G-1:0], col_q};
      ST_CALC: begin
        old_q       <= dt_rdata[63:32];
        ov_q        <= dt_rdata[31:0];
        res_hit_q   <= 1'b1;
        res_first_q <= !kn_rdata;
        if (!kn_rdata) begin
          res_elev_q <= pz_q;
          res_var_q  <= VAR_INIT;
        end else if (gmode_q) begin
          res_elev_q <= gsum[32:1];
          res_var_q  <= {1'b0, dt_rdata[31:1]};
        end
      end
      ST_MAG: begin
        res_elev_q <= blend_elev;
        mag_q      <= resid[32] ? -resid : resid;
      end
      ST_SQ: sq_q <= acc_q[64:16];
      ST_VAR: begin
        // variance saturates at all ones
        res_var_q <= (acc_q[ACC_W-1:48] != '0) ? '1 : acc_q[47:16];
      end
      ST_DONE: begin
        if (out_free) begin
          out_hit_q   <= res_hit_q;
          out_first_q <= res_first_q;
          out_cell_q  <= res_hit_q ? cell_pad[15:0] : 16'd0;
          out_elev_q  <= res_elev_q;
          out_var_q   <= res_var_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign first_hit_o     = out_first_q;
  assign cell_index_o    = out_cell_q;
  assign new_elevation_o = out_elev_q;
  assign new_variance_o  = out_var_q;

endmodule

[sv/egf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the cell stores of the elevation grid fuser.
module egf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
